// File: hdl/mi3_pkg.sv
// Shared constants, widths and types for the 3x3 matrix inverse.
package mi3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int N_ELEM    = 9;
    localparam int N_ROW     = 3;

    // Exact intermediate widths
    localparam int PROD_W = 2 * WORD_BITS;            // one element product
    localparam int ADJ_W  = PROD_W + 1;               // adjugate entry, signed
    localparam int MAG_W  = PROD_W;                   // |adjugate|
    localparam int PART_W = 2 * WORD_BITS + 1;        // element times adj half
    localparam int DET_W  = 3 * WORD_BITS + 1;        // determinant, signed
    localparam int DMAG_W = 3 * WORD_BITS;            // |determinant|
    localparam int DEN_W  = DMAG_W + 1;               // 2*|determinant|
    localparam int NUM_W  = ((MAG_W + 2 * FRAC_BITS + 1) > DMAG_W ?
                             (MAG_W + 2 * FRAC_BITS + 1) : DMAG_W) + 1;
    localparam int REM_W  = (NUM_W > DEN_W + WORD_BITS) ? NUM_W : DEN_W + WORD_BITS;
    localparam int QB     = WORD_BITS;                // quotient bits, one per stage
    localparam int NS     = QB + 6;                   // pipeline stages

    // adj[i] = m[X]*m[Y] - m[U]*m[V], row-major element order
    localparam int COF_X [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_Y [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_U [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int COF_V [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef t_word t_mat [N_ELEM];

endpackage

// File: hdl/mi3_if.sv
// Handshake channels: matrix in, inverse out.
interface mi3_in_if;
    import mi3_pkg::*;
    logic  valid;
    logic  ready;
    t_word a00, a01, a02, a10, a11, a12, a20, a21, a22;
    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    output ready);
endinterface

interface mi3_out_if;
    import mi3_pkg::*;
    logic  valid;
    logic  ready;
    t_word r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic  singular;
    logic  overflowed;
    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, overflowed, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, overflowed, output ready);
endinterface

// File: hdl/matrix_inverse_3x3_top.sv
// 3x3 matrix inverse by adjugate over determinant, signed Q16.16, fully pipelined.
// One matrix word is taken every cycle and one result word leaves every cycle while the output
// is not stalled. The restoring divider resolves one quotient bit per stage for all nine
// elements at once. Front stages: element products, adjugate, determinant partial products,
// determinant sum, divider setup. Each stage holds its word while the one after it is full and
// stalled, so bubbles close up and nothing is dropped.
// A zero determinant passes the input through with singular set; each element is
// rounded to nearest (ties away from zero) and saturated, saturation raising overflowed.
module matrix_inverse_3x3_top (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mi3_in_if.sink   i_in,
    mi3_out_if.source o_out
);
    import mi3_pkg::*;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;
    t_mat          in_mat;

    // Stage payloads
    logic signed [PROD_W-1:0] r_p1 [N_ELEM];
    logic signed [PROD_W-1:0] r_p2 [N_ELEM];
    t_mat                     r_mat0, r_mat1, r_mat2, r_mat3;
    logic signed [ADJ_W-1:0]  r_adj1 [N_ELEM];
    logic signed [ADJ_W-1:0]  r_adj2 [N_ELEM];
    logic signed [ADJ_W-1:0]  r_adj3 [N_ELEM];
    logic signed [PART_W-1:0] r_dlo [N_ROW];
    logic signed [PART_W-1:0] r_dhi [N_ROW];
    logic signed [DET_W-1:0]  r_det;

    // Divider pipeline, index 0 is setup
    logic [REM_W-1:0] r_rem  [0:QB][N_ELEM];
    logic [QB-1:0]    r_qt   [0:QB][N_ELEM];
    logic [N_ELEM-1:0] r_neg [0:QB];
    logic [N_ELEM-1:0] r_big [0:QB];
    logic [DEN_W-1:0] r_den  [0:QB];
    logic             r_sing [0:QB];
    t_mat             r_dmat [0:QB];

    // Output register
    t_word r_res [N_ELEM];
    logic  r_sing_o;
    logic  r_ovf_o;

    // Stall chain: a stage loads when it is empty or its word moves on
    assign en[NS-1] = !r_v[NS-1] || o_out.ready;
    for (genvar s = 0; s < NS - 1; s++) begin : g_en
        assign en[s] = !r_v[s] || en[s+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign i_in.ready = en[0];

    always_comb begin
        in_mat[0] = i_in.a00; in_mat[1] = i_in.a01; in_mat[2] = i_in.a02;
        in_mat[3] = i_in.a10; in_mat[4] = i_in.a11; in_mat[5] = i_in.a12;
        in_mat[6] = i_in.a20; in_mat[7] = i_in.a21; in_mat[8] = i_in.a22;
    end

    // Stage 0: cofactor products
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_p1[i] <= PROD_W'(in_mat[COF_X[i]]) * PROD_W'(in_mat[COF_Y[i]]);
                r_p2[i] <= PROD_W'(in_mat[COF_U[i]]) * PROD_W'(in_mat[COF_V[i]]);
            end
            r_mat0 <= in_mat;
        end
    end

    // Stage 1: adjugate
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_adj1[i] <= ADJ_W'(r_p1[i]) - ADJ_W'(r_p2[i]);
            end
            r_mat1 <= r_mat0;
        end
    end

    // Stage 2: determinant partial products, adj split into signed high and unsigned low
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int k = 0; k < N_ROW; k++) begin
                r_dlo[k] <= PART_W'(r_mat1[k])
                            * PART_W'($signed({1'b0, r_adj1[3*k][WORD_BITS-1:0]}));
                r_dhi[k] <= PART_W'(r_mat1[k])
                            * PART_W'($signed(r_adj1[3*k][ADJ_W-1:WORD_BITS]));
            end
            r_adj2 <= r_adj1;
            r_mat2 <= r_mat1;
        end
    end

    // Stage 3: determinant sum
    logic signed [DET_W+1:0] det_sum;
    always_comb begin
        det_sum = '0;
        for (int k = 0; k < N_ROW; k++) begin
            det_sum = det_sum + ((DET_W+2)'(r_dhi[k]) <<< WORD_BITS) + (DET_W+2)'(r_dlo[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_det  <= det_sum[DET_W-1:0];
            r_adj3 <= r_adj2;
            r_mat3 <= r_mat2;
        end
    end

    // Stage 4: magnitudes, rounding offset, overflow precheck
    logic [DMAG_W-1:0] dmag;
    logic [DEN_W-1:0]  den0;
    logic [ADJ_W-1:0]  amag_w [N_ELEM];
    logic [REM_W-1:0]  num0   [N_ELEM];
    logic [N_ELEM-1:0] neg0, big0;
    always_comb begin
        dmag = r_det[DET_W-1] ? DMAG_W'(-r_det) : DMAG_W'(r_det);
        den0 = {dmag, 1'b0};
        for (int i = 0; i < N_ELEM; i++) begin
            amag_w[i] = r_adj3[i][ADJ_W-1] ? ADJ_W'(-r_adj3[i]) : ADJ_W'(r_adj3[i]);
            num0[i]   = (REM_W'(amag_w[i][MAG_W-1:0]) << (2 * FRAC_BITS + 1))
                        + REM_W'(dmag);
            neg0[i]   = (r_adj3[i][ADJ_W-1] ^ r_det[DET_W-1]) && (r_adj3[i] != '0);
            big0[i]   = num0[i] >= (REM_W'(den0) << QB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_rem[0]  <= num0;
            for (int i = 0; i < N_ELEM; i++) begin
                r_qt[0][i] <= '0;
            end
            r_neg[0]  <= neg0;
            r_big[0]  <= big0;
            r_den[0]  <= den0;
            r_sing[0] <= (r_det == '0);
            r_dmat[0] <= r_mat3;
        end
    end

    // Divider stages: one quotient bit per stage, MSB first
    for (genvar k = 1; k <= QB; k++) begin : g_div
        logic [REM_W:0]   trial [N_ELEM];
        logic [REM_W-1:0] dsh;
        always_comb begin
            dsh = REM_W'(r_den[k-1]) << (QB - k);
            for (int i = 0; i < N_ELEM; i++) begin
                trial[i] = {1'b0, r_rem[k-1][i]} - {1'b0, dsh};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[4+k]) begin
                for (int i = 0; i < N_ELEM; i++) begin
                    if (!trial[i][REM_W]) begin
                        r_rem[k][i] <= trial[i][REM_W-1:0];
                        r_qt[k][i]  <= r_qt[k-1][i] | (QB'(1) << (QB - k));
                    end else begin
                        r_rem[k][i] <= r_rem[k-1][i];
                        r_qt[k][i]  <= r_qt[k-1][i];
                    end
                end
                r_neg[k]  <= r_neg[k-1];
                r_big[k]  <= r_big[k-1];
                r_den[k]  <= r_den[k-1];
                r_sing[k] <= r_sing[k-1];
                r_dmat[k] <= r_dmat[k-1];
            end
        end
    end

    // Output stage: saturate, apply sign, singular bypass
    logic [QB-1:0]     lim [N_ELEM];
    logic [QB-1:0]     mag [N_ELEM];
    logic [N_ELEM-1:0] sat;
    t_word             res [N_ELEM];
    always_comb begin
        for (int i = 0; i < N_ELEM; i++) begin
            lim[i] = r_neg[QB][i] ? (QB'(1) << (QB - 1)) : ((QB'(1) << (QB - 1)) - QB'(1));
            sat[i] = r_big[QB][i] || (r_qt[QB][i] > lim[i]);
            mag[i] = sat[i] ? lim[i] : r_qt[QB][i];
            res[i] = r_neg[QB][i] ? t_word'(-mag[i]) : t_word'(mag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_sing_o <= r_sing[QB];
            r_ovf_o  <= !r_sing[QB] && (sat != '0);
            r_res    <= r_sing[QB] ? r_dmat[QB] : res;
        end
    end

    assign o_out.valid      = r_v[NS-1];
    assign o_out.r00        = r_res[0];
    assign o_out.r01        = r_res[1];
    assign o_out.r02        = r_res[2];
    assign o_out.r10        = r_res[3];
    assign o_out.r11        = r_res[4];
    assign o_out.r12        = r_res[5];
    assign o_out.r20        = r_res[6];
    assign o_out.r21        = r_res[7];
    assign o_out.r22        = r_res[8];
    assign o_out.singular   = r_sing_o;
    assign o_out.overflowed = r_ovf_o;

`ifndef NO_ASSERTIONS
    // a singular word never reports saturation
    a_sing_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.singular |-> !o_out.overflowed)
        else $error("singular result flagged overflowed");

    // reset empties the whole pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_v == '0))
        else $error("pipeline not empty after reset");

    // divider finishes with remainder below divisor when no early overflow
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-2] && !r_sing[QB] && !r_big[QB][0] |-> (r_rem[QB][0] < REM_W'(r_den[QB])))
        else $error("divider remainder out of range");

    // a stalled output word is not overwritten by the stage behind it
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] && !o_out.ready |=> r_v[NS-1] && $stable(r_res[0]))
        else $error("stalled output word changed");
`endif

endmodule

// File: tb/sv/mi3_tb_util.sv
// Interface-free helpers are not needed; this file holds the testbench top.
module matrix_inverse_3x3_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mi3_pkg::*;

    typedef struct {
        t_word m [N_ELEM];
        logic  singular;
        logic  overflowed;
    } t_inverse;

    logic i_clk;
    logic i_rst_n;
    mi3_in_if  mat_if ();
    mi3_out_if inv_if ();

    matrix_inverse_3x3_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (mat_if.sink),
        .o_out   (inv_if.source)
    );

    t_inverse inverse_q [$];
    int       n_errors;
    int       send_idle_pct;
    int       stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit: 1846 words, with time for them several times over
    initial begin
        #20ms;
        $display("matrix_inverse_3x3_top_tb: FAIL");
        $finish;
    end

    // Exact inverse: adjugate over determinant, rounded half away, saturated
    function automatic t_inverse inverse_of(t_word a [N_ELEM]);
        t_inverse res;
        logic signed [ADJ_W-1:0]  adj [N_ELEM];
        logic signed [DET_W+1:0]  det;
        logic [255:0] num, den, quo, lim, amag, dmag;
        logic neg;
        res.singular = 1'b0;
        res.overflowed = 1'b0;
        for (int i = 0; i < N_ELEM; i++)
            adj[i] = ADJ_W'(a[COF_X[i]]) * ADJ_W'(a[COF_Y[i]])
                   - ADJ_W'(a[COF_U[i]]) * ADJ_W'(a[COF_V[i]]);
        det = (DET_W+2)'(a[0]) * (DET_W+2)'(adj[0])
            + (DET_W+2)'(a[1]) * (DET_W+2)'(adj[3])
            + (DET_W+2)'(a[2]) * (DET_W+2)'(adj[6]);
        if (det == 0) begin
            res.m = a;
            res.singular = 1'b1;
            return res;
        end
        dmag = 256'(det < 0 ? -det : det);
        for (int i = 0; i < N_ELEM; i++) begin
            amag = 256'(adj[i] < 0 ? -adj[i] : adj[i]);
            neg  = (adj[i] < 0) != (det < 0) && amag != 0;
            num  = (amag << (2 * FRAC_BITS + 1)) + dmag;
            den  = dmag << 1;
            quo  = num / den;
            lim  = (256'(1) << (WORD_BITS - 1)) - (neg ? 0 : 1);
            if (quo > lim) begin
                quo = lim;
                res.overflowed = 1'b1;
            end
            res.m[i] = neg ? -t_word'(quo) : t_word'(quo);
        end
        return res;
    endfunction

    // Send one matrix word, with random idle before it
    task automatic send_matrix(t_word a [N_ELEM]);
        while ($urandom_range(99) < send_idle_pct) begin
            mat_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        inverse_q.push_back(inverse_of(a));
        mat_if.valid <= 1'b1;
        {mat_if.a00, mat_if.a01, mat_if.a02} <= {a[0], a[1], a[2]};
        {mat_if.a10, mat_if.a11, mat_if.a12} <= {a[3], a[4], a[5]};
        {mat_if.a20, mat_if.a21, mat_if.a22} <= {a[6], a[7], a[8]};
        do @(posedge i_clk); while (!mat_if.ready);
    endtask

    // Receiver: random stall, compare every accepted word
    always @(posedge i_clk) begin
        t_inverse exp_inv;
        t_word got [N_ELEM];
        inv_if.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
        if (i_rst_n && inv_if.valid && inv_if.ready) begin
            got = '{inv_if.r00, inv_if.r01, inv_if.r02, inv_if.r10, inv_if.r11,
                    inv_if.r12, inv_if.r20, inv_if.r21, inv_if.r22};
            if (inverse_q.size() == 0) begin
                $display("%t: unexpected word r00=%h", $realtime, got[0]);
                n_errors++;
            end else begin
                exp_inv = inverse_q.pop_front();
                for (int i = 0; i < N_ELEM; i++)
                    if (got[i] !== exp_inv.m[i]) begin
                        $display("%t: element %0d expected %h actual %h",
                                 $realtime, i, exp_inv.m[i], got[i]);
                        n_errors++;
                    end
                if (inv_if.singular !== exp_inv.singular) begin
                    $display("%t: singular expected %b actual %b",
                             $realtime, exp_inv.singular, inv_if.singular);
                    n_errors++;
                end
                if (inv_if.overflowed !== exp_inv.overflowed) begin
                    $display("%t: overflowed expected %b actual %b",
                             $realtime, exp_inv.overflowed, inv_if.overflowed);
                    n_errors++;
                end
            end
        end
    end

    function automatic t_word rand_elem(int mode);
        case (mode)
            0: return t_word'($urandom);
            1: return t_word'($urandom_range(262143)) - t_word'(131072);
            2: return t_word'($urandom_range(8191)) - t_word'(4096);
            default: return t_word'($urandom_range(16)) - t_word'(8) <<< FRAC_BITS;
        endcase
    endfunction

    // Edge cases: identity, extremes, singular, overflow, scaled identities
    task automatic test_directed();
        t_word a [N_ELEM];
        t_word one, mx, mn;
        one = t_word'(1) <<< FRAC_BITS;
        mx = {1'b0, {(WORD_BITS-1){1'b1}}};
        mn = {1'b1, {(WORD_BITS-1){1'b0}}};
        a = '{one, 0, 0, 0, one, 0, 0, 0, one};  send_matrix(a);
        a = '{-one, 0, 0, 0, one, 0, 0, 0, -one}; send_matrix(a);
        a = '{default: 0};                        send_matrix(a);
        a = '{default: mx};                       send_matrix(a);
        a = '{default: mn};                       send_matrix(a);
        a = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};      send_matrix(a);
        a = '{mn, 0, 0, 0, mn, 0, 0, 0, mn};      send_matrix(a);
        a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};         send_matrix(a);
        a = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};        send_matrix(a);
        // exact negative limit: a diagonal of -2 LSB gives -32768.0 through a tiny det
        a = '{-2, 0, 0, 0, one, 0, 0, 0, one};    send_matrix(a);
        a = '{2, 0, 0, 0, one, 0, 0, 0, one};     send_matrix(a);
        a = '{mx, mn, 0, mn, mx, 0, 0, 0, one};   send_matrix(a);
        a = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 9*one};
        send_matrix(a);
        a = '{2*one, one, 0, one, 2*one, one, 0, one, 2*one}; send_matrix(a);
        a = '{3, 0, 0, 0, 3, 0, 0, 0, 3};         send_matrix(a);
        a = '{mx, mn, mx, mn, mx, mn, mx, mn, -1}; send_matrix(a);
    endtask

    // Random matrices of mixed magnitude, some made singular by a repeated row
    task automatic test_random(int count);
        t_word a [N_ELEM];
        int mode;
        repeat (count) begin
            mode = $urandom_range(3);
            for (int i = 0; i < N_ELEM; i++) a[i] = rand_elem(mode);
            if ($urandom_range(9) == 0) a[6:8] = a[0:2];
            send_matrix(a);
        end
    endtask

    initial begin
        int wait_cycles;
        n_errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        mat_if.valid = 1'b0;
        {mat_if.a00, mat_if.a01, mat_if.a02, mat_if.a10, mat_if.a11,
         mat_if.a12, mat_if.a20, mat_if.a21, mat_if.a22} = '0;
        inv_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(450);
        send_idle_pct = 65;
        test_random(450);
        send_idle_pct = 0;
        stall_pct = 65;
        test_random(450);
        send_idle_pct = 9;
        stall_pct = 9;
        test_random(480);
        mat_if.valid <= 1'b0;
        wait_cycles = 0;
        while (inverse_q.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (NS + 10) @(posedge i_clk);
        if (n_errors == 0 && inverse_q.size() == 0)
            $display("matrix_inverse_3x3_top_tb: PASS");
        else
            $display("matrix_inverse_3x3_top_tb: FAIL");
        $finish;
    end
endmodule
